// ----- hdl/virtio_mmio_block_register_file_defines.svh -----
// Assertion macros used by the checker of the register file.
`ifndef VIRTIO_MMIO_BLOCK_REGISTER_FILE_DEFINES_SVH
`define VIRTIO_MMIO_BLOCK_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VMB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VMB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/vmblk_pkg.sv -----
package vmblk_pkg;

   localparam int unsigned OffsetWidth = 9;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned WideWidth   = 64;
   localparam int unsigned CsrAddrWidth = 4;

   typedef logic [OffsetWidth-1:0] offset_type;
   typedef logic [WordWidth-1:0]   word_type;
   typedef logic [WideWidth-1:0]   wide_type;

   typedef enum logic [1:0] {
      OUTCOME_OK       = 2'd0,
      OUTCOME_UNKNOWN  = 2'd1,
      OUTCOME_NONZERO  = 2'd2
   } outcome_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // Identification constants
   localparam word_type MAGIC_VALUE     = 32'h7472_6976;
   localparam word_type VERSION_VALUE   = 32'd2;
   localparam word_type DEVICE_ID_VALUE = 32'd2;
   localparam word_type VENDOR_ID_VALUE = 32'h554D_4551;
   localparam word_type QUEUE_MAX_VALUE = 32'd1024;
   localparam word_type IRQ_STATUS_VALUE = 32'd1;

   localparam wide_type FEATURES_RESET = 64'h0000_0001_0000_0000;

   // Register offsets
   localparam offset_type OFS_MAGIC        = 9'h000;
   localparam offset_type OFS_VERSION      = 9'h004;
   localparam offset_type OFS_DEVICE_ID    = 9'h008;
   localparam offset_type OFS_VENDOR_ID    = 9'h00C;
   localparam offset_type OFS_DEV_FEAT     = 9'h010;
   localparam offset_type OFS_DEV_FEAT_SEL = 9'h014;
   localparam offset_type OFS_DRV_FEAT     = 9'h020;
   localparam offset_type OFS_DRV_FEAT_SEL = 9'h024;
   localparam offset_type OFS_QUEUE_SEL    = 9'h030;
   localparam offset_type OFS_QUEUE_MAX    = 9'h034;
   localparam offset_type OFS_QUEUE_SIZE   = 9'h038;
   localparam offset_type OFS_QUEUE_READY  = 9'h044;
   localparam offset_type OFS_NOTIFY       = 9'h050;
   localparam offset_type OFS_IRQ_STATUS   = 9'h060;
   localparam offset_type OFS_IRQ_ACK      = 9'h064;
   localparam offset_type OFS_STATUS       = 9'h070;
   localparam offset_type OFS_DESC_LO      = 9'h080;
   localparam offset_type OFS_DESC_HI      = 9'h084;
   localparam offset_type OFS_AVAIL_LO     = 9'h090;
   localparam offset_type OFS_AVAIL_HI     = 9'h094;
   localparam offset_type OFS_USED_LO      = 9'h0A0;
   localparam offset_type OFS_USED_HI      = 9'h0A4;
   localparam offset_type OFS_CFG_GEN      = 9'h0FC;
   localparam offset_type OFS_CAP_LO       = 9'h100;
   localparam offset_type OFS_CAP_HI       = 9'h104;

   // Configuration register indexes (paddr bit 3)
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_FEATURES = 1'b1;

endpackage

// ----- hdl/vmblk_ifs.sv -----
interface vmblk_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [vmblk_pkg::OffsetWidth-1:0] reg_offset;
   logic [vmblk_pkg::WordWidth-1:0]   write_data;

   modport source (output valid, operation, reg_offset, write_data, input ready);
   modport sink   (input valid, operation, reg_offset, write_data, output ready);
endinterface

interface vmblk_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vmblk_pkg::WordWidth-1:0] read_data;
   logic                           irq_level;
   logic                           notify_pulse;
   logic [1:0]                     outcome;

   modport source (output valid, read_data, irq_level, notify_pulse, outcome, input ready);
   modport sink   (input valid, read_data, irq_level, notify_pulse, outcome, output ready);
endinterface

// ----- hdl/virtio_mmio_block_register_file.sv -----
// Channel   | Dir | Handshake        | Payload
// req_if    | in  | valid / ready    | operation, reg_offset, write_data
// rsp_if    | out | valid / ready    | read_data, irq_level, notify_pulse, outcome
// csr_*     | in  | APB psel/penable | capacity at 0x0, device features at 0x8
//
// Each item gives exactly one result after acceptance: it passes through the
// input register, then the result register.
// Throughput is one item per cycle while results are taken; decode and register
// update sit in the single stage between the input register and the result register.
// Reset is synchronous, active high: pipeline empty, registers at power-on
// values. A stalled result holds the pipe; the input register still takes an item
// while the result register is waiting, if it is empty, so one item rides the stall.
module virtio_mmio_block_register_file (
   input  logic                                 clock,
   input  logic                                 reset,
   vmblk_req_if.sink                            req_if,
   vmblk_rsp_if.source                          rsp_if,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vmblk_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [vmblk_pkg::WideWidth-1:0]      csr_pwdata,
   output logic [vmblk_pkg::WideWidth-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // ---------------- configuration registers ----------------
   vmblk_pkg::word_type capacity_ff;
   vmblk_pkg::wide_type features_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Only bit 3 of paddr selects the register; byte lanes below are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         features_ff <= vmblk_pkg::FEATURES_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3])
            vmblk_pkg::CSR_CAPACITY: capacity_ff <= csr_pwdata[vmblk_pkg::WordWidth-1:0];
            vmblk_pkg::CSR_FEATURES: features_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         vmblk_pkg::CSR_CAPACITY:
            csr_prdata = {{(vmblk_pkg::WideWidth-vmblk_pkg::WordWidth){1'b0}}, capacity_ff};
         vmblk_pkg::CSR_FEATURES: csr_prdata = features_ff;
         default: csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   vmblk_pkg::offset_type s1_offset_ff;
   vmblk_pkg::word_type   s1_data_ff;

   logic                  out_valid_ff;
   vmblk_pkg::word_type   out_read_data_ff;
   logic                  out_irq_ff;
   logic                  out_notify_ff;
   vmblk_pkg::outcome_type out_outcome_ff;

   logic advance;   // result register free to load
   logic s1_fire;   // item moves from input register to result register

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_op_ff     <= req_if.operation;
         s1_offset_ff <= req_if.reg_offset;
         s1_data_ff   <= req_if.write_data;
      end
   end

   // ---------------- device state ----------------
   vmblk_pkg::word_type status_ff,        status_in;
   vmblk_pkg::word_type feat_sel_ff,      feat_sel_in;
   vmblk_pkg::word_type drv_feat_ff,      drv_feat_in;
   vmblk_pkg::word_type drv_feat_sel_ff,  drv_feat_sel_in;
   vmblk_pkg::word_type queue_sel_ff,     queue_sel_in;
   vmblk_pkg::word_type queue_size_ff,    queue_size_in;
   vmblk_pkg::word_type queue_ready_ff,   queue_ready_in;
   vmblk_pkg::wide_type desc_addr_ff,     desc_addr_in;
   vmblk_pkg::wide_type avail_addr_ff,    avail_addr_in;
   vmblk_pkg::wide_type used_addr_ff,     used_addr_in;
   logic                irq_ff,           irq_in;

   vmblk_pkg::word_type    rd_value;
   vmblk_pkg::outcome_type outcome_value;
   logic                   notify_value;
   logic                   data_nonzero;

   assign data_nonzero = |s1_data_ff;

   // Decode and update: one access, one case on the offset.
   always_comb begin
      status_in       = status_ff;
      feat_sel_in     = feat_sel_ff;
      drv_feat_in     = drv_feat_ff;
      drv_feat_sel_in = drv_feat_sel_ff;
      queue_sel_in    = queue_sel_ff;
      queue_size_in   = queue_size_ff;
      queue_ready_in  = queue_ready_ff;
      desc_addr_in    = desc_addr_ff;
      avail_addr_in   = avail_addr_ff;
      used_addr_in    = used_addr_ff;
      irq_in          = irq_ff;
      rd_value        = '0;
      outcome_value   = vmblk_pkg::OUTCOME_OK;
      notify_value    = 1'b0;

      if (s1_op_ff == vmblk_pkg::OP_WRITE) begin
         case (s1_offset_ff)
            vmblk_pkg::OFS_DEV_FEAT_SEL: feat_sel_in     = s1_data_ff;
            vmblk_pkg::OFS_DRV_FEAT:     drv_feat_in     = s1_data_ff;
            vmblk_pkg::OFS_DRV_FEAT_SEL: drv_feat_sel_in = s1_data_ff;
            vmblk_pkg::OFS_QUEUE_SEL: begin
               // only queue 0 exists; other values are kept but flagged
               queue_sel_in = s1_data_ff;
               if (data_nonzero) outcome_value = vmblk_pkg::OUTCOME_NONZERO;
            end
            vmblk_pkg::OFS_QUEUE_SIZE:   queue_size_in   = s1_data_ff;
            vmblk_pkg::OFS_QUEUE_READY:  queue_ready_in  = s1_data_ff;
            vmblk_pkg::OFS_NOTIFY: begin
               irq_in       = 1'b1;
               notify_value = 1'b1;
               if (data_nonzero) outcome_value = vmblk_pkg::OUTCOME_NONZERO;
            end
            vmblk_pkg::OFS_IRQ_ACK:      irq_in          = 1'b0;
            vmblk_pkg::OFS_STATUS:       status_in       = s1_data_ff;
            vmblk_pkg::OFS_DESC_LO:      desc_addr_in[31:0]   = s1_data_ff;
            vmblk_pkg::OFS_DESC_HI:      desc_addr_in[63:32]  = s1_data_ff;
            vmblk_pkg::OFS_AVAIL_LO:     avail_addr_in[31:0]  = s1_data_ff;
            vmblk_pkg::OFS_AVAIL_HI:     avail_addr_in[63:32] = s1_data_ff;
            vmblk_pkg::OFS_USED_LO:      used_addr_in[31:0]   = s1_data_ff;
            vmblk_pkg::OFS_USED_HI:      used_addr_in[63:32]  = s1_data_ff;
            default:                     outcome_value = vmblk_pkg::OUTCOME_UNKNOWN;
         endcase
      end else begin
         case (s1_offset_ff)
            vmblk_pkg::OFS_MAGIC:       rd_value = vmblk_pkg::MAGIC_VALUE;
            vmblk_pkg::OFS_VERSION:     rd_value = vmblk_pkg::VERSION_VALUE;
            vmblk_pkg::OFS_DEVICE_ID:   rd_value = vmblk_pkg::DEVICE_ID_VALUE;
            vmblk_pkg::OFS_VENDOR_ID:   rd_value = vmblk_pkg::VENDOR_ID_VALUE;
            vmblk_pkg::OFS_DEV_FEAT: begin
               // select beyond the high half reads zero
               if (feat_sel_ff == 32'd0)      rd_value = features_ff[31:0];
               else if (feat_sel_ff == 32'd1) rd_value = features_ff[63:32];
               else                           rd_value = '0;
            end
            vmblk_pkg::OFS_QUEUE_MAX:   rd_value = vmblk_pkg::QUEUE_MAX_VALUE;
            vmblk_pkg::OFS_QUEUE_READY: rd_value = queue_ready_ff;
            vmblk_pkg::OFS_IRQ_STATUS:  rd_value = vmblk_pkg::IRQ_STATUS_VALUE;
            vmblk_pkg::OFS_STATUS:      rd_value = status_ff;
            vmblk_pkg::OFS_CFG_GEN:     rd_value = '0;
            vmblk_pkg::OFS_CAP_LO:      rd_value = capacity_ff;
            vmblk_pkg::OFS_CAP_HI:      rd_value = '0;
            default:                    outcome_value = vmblk_pkg::OUTCOME_UNKNOWN;
         endcase
      end
   end

   // State moves only when the item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff       <= '0;
         feat_sel_ff     <= '0;
         drv_feat_ff     <= '0;
         drv_feat_sel_ff <= '0;
         queue_sel_ff    <= '0;
         queue_size_ff   <= '0;
         queue_ready_ff  <= '0;
         desc_addr_ff    <= '0;
         avail_addr_ff   <= '0;
         used_addr_ff    <= '0;
         irq_ff          <= 1'b0;
      end else if (s1_fire) begin
         status_ff       <= status_in;
         feat_sel_ff     <= feat_sel_in;
         drv_feat_ff     <= drv_feat_in;
         drv_feat_sel_ff <= drv_feat_sel_in;
         queue_sel_ff    <= queue_sel_in;
         queue_size_ff   <= queue_size_in;
         queue_ready_ff  <= queue_ready_in;
         desc_addr_ff    <= desc_addr_in;
         avail_addr_ff   <= avail_addr_in;
         used_addr_ff    <= used_addr_in;
         irq_ff          <= irq_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_read_data_ff <= rd_value;
         out_irq_ff       <= irq_in;
         out_notify_ff    <= notify_value;
         out_outcome_ff   <= outcome_value;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.read_data    = out_read_data_ff;
   assign rsp_if.irq_level    = out_irq_ff;
   assign rsp_if.notify_pulse = out_notify_ff;
   assign rsp_if.outcome      = out_outcome_ff;

endmodule

// ----- hdl/vmblk_chk.sv -----
`include "virtio_mmio_block_register_file_defines.svh"

module vmblk_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [vmblk_pkg::WordWidth-1:0] rsp_read_data,
   input logic                            rsp_irq_level,
   input logic                            rsp_notify_pulse,
   input logic [1:0]                      rsp_outcome
);

   `VMB_ASSERT_NOW(a_notify_raises_irq, clock, reset, rsp_valid && rsp_notify_pulse, rsp_irq_level, "notify item without interrupt")

   `VMB_ASSERT_NOW(a_unknown_quiet, clock, reset, rsp_valid && (rsp_outcome == vmblk_pkg::OUTCOME_UNKNOWN), (rsp_read_data == '0) && !rsp_notify_pulse, "unknown offset item carries data or notify")

   `VMB_ASSERT_NOW(a_outcome_legal, clock, reset, rsp_valid, (rsp_outcome == vmblk_pkg::OUTCOME_OK) || (rsp_outcome == vmblk_pkg::OUTCOME_UNKNOWN) || (rsp_outcome == vmblk_pkg::OUTCOME_NONZERO), "outcome code out of range")

   `VMB_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_level) && $stable(rsp_outcome), "stalled item changed")

endmodule

bind virtio_mmio_block_register_file vmblk_chk u_vmblk_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_read_data    (rsp_if.read_data),
   .rsp_irq_level    (rsp_if.irq_level),
   .rsp_notify_pulse (rsp_if.notify_pulse),
   .rsp_outcome      (rsp_if.outcome)
);
